@@ hdl/time_of_day_clock_with_check_flags_core_defines.svh @@
// Assertion macros for the time-of-day clock core.
// Included by the top level; no other dependencies.
`ifndef TIME_OF_DAY_CLOCK_WITH_CHECK_FLAGS_CORE_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_CHECK_FLAGS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TOD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tod core assertion failed");
// Next-cycle implication.
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tod core assertion failed");
`else
`define TOD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/tod_pkg.sv @@
// Shared types, function codes and constants for the time-of-day clock core.
// No dependencies.
`default_nettype none
package tod_pkg;

    // Function codes of an input beat
    localparam logic [2:0] FUNC_TICK         = 3'd0;
    localparam logic [2:0] FUNC_SET_TIME     = 3'd1;
    localparam logic [2:0] FUNC_TAKE_CHECK   = 3'd2;
    localparam logic [2:0] FUNC_TAKE_LATE    = 3'd3;
    localparam logic [2:0] FUNC_TAKE_CLIENTS = 3'd4;

    // Configuration register indexes
    localparam logic CFG_CHECK_PERIOD  = 1'b0;
    localparam logic CFG_CLIENT_PERIOD = 1'b1;

    localparam logic [15:0] CHECK_PERIOD_RESET  = 16'd120;
    localparam logic [7:0]  CLIENT_PERIOD_RESET = 8'd30;

    localparam logic [15:0] LATE_LIMIT       = 16'd10;
    localparam logic [7:0]  CLIENT_WINDOW    = 8'd5;
    localparam logic [4:0]  MAX_HOUR         = 5'd23;
    localparam logic [5:0]  UNITS_PER_MINUTE = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY    = 5'd24;
    localparam logic [15:0] STOPWATCH_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [2:0] func;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [5:0] new_second;
    } in_item_t;

    typedef struct packed {
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       answer;
    } out_item_t;

    // Decoded function of the beat being processed
    typedef struct packed {
        logic tick;
        logic set_time;
        logic take_check;
        logic take_late;
        logic take_clients;
    } tod_cmd_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_time_t;

    typedef struct packed {
        logic check_pending;
        logic check_late;
        logic clients_pending;
    } tod_flag_status_t;

endpackage
`default_nettype wire

@@ hdl/tod_time.sv @@
// Hours/minutes/seconds counter with validated set-time load.
// Depends on tod_pkg.
`default_nettype none
module tod_time
    import tod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire tod_cmd_t  cmd,
    input  wire in_item_t  item,
    output tod_time_t      time_next,
    output logic           set_ok
);

    tod_time_t time_reg;

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic       min_carry;
    logic       hour_carry;
    tod_time_t  ticked;

    always_comb
    begin
        sec_inc    = {1'b0, time_reg.second} + 7'd1;
        min_carry  = (sec_inc >= {1'b0, UNITS_PER_MINUTE});
        ticked.second = min_carry ? 6'd0 : sec_inc[5:0];
        min_inc    = {1'b0, time_reg.minute} + {6'd0, min_carry};
        hour_carry = (min_inc >= {1'b0, UNITS_PER_MINUTE});
        ticked.minute = hour_carry ? 6'd0 : min_inc[5:0];
        hour_inc   = {1'b0, time_reg.hour} + {5'd0, hour_carry};
        ticked.hour = (hour_inc >= {1'b0, HOURS_PER_DAY}) ? 5'd0 : hour_inc[4:0];

        set_ok = cmd.set_time && (item.new_hour <= MAX_HOUR)
                 && (item.new_minute < UNITS_PER_MINUTE)
                 && (item.new_second < UNITS_PER_MINUTE);

        if (cmd.tick)
        begin
            time_next = ticked;
        end
        else if (set_ok)
        begin
            time_next.hour   = item.new_hour;
            time_next.minute = item.new_minute;
            time_next.second = item.new_second;
        end
        else
        begin
            time_next = time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (fire)
        begin
            time_reg <= time_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/tod_flags.sv @@
// Stopwatch, client phase and the three sticky flags with poll-and-clear.
// Depends on tod_pkg.
`default_nettype none
module tod_flags
    import tod_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire tod_cmd_t    cmd,
    input  wire logic [15:0] check_period,
    input  wire logic [7:0]  client_period,
    output logic             poll_answer,
    output tod_flag_status_t status
);

    logic [15:0]      stopwatch_reg, stopwatch_next;
    logic [7:0]       phase_reg, phase_next;
    tod_flag_status_t flags_reg, flags_next;

    logic        raise;
    logic [15:0] sw1;
    logic [7:0]  ph1;
    logic        cp1;
    logic        late1;
    logic [8:0]  ph_inc;

    assign status = flags_reg;

    always_comb
    begin
        // tick path: check raise, late, clients window, then count
        raise = (stopwatch_reg >= check_period) && !flags_reg.clients_pending;
        sw1   = raise ? 16'd0 : stopwatch_reg;
        ph1   = raise ? 8'd0 : phase_reg;
        cp1   = raise | flags_reg.check_pending;
        late1 = raise ? 1'b0 : flags_reg.check_late;
        ph_inc = {1'b0, ph1} + 9'd1;

        stopwatch_next = stopwatch_reg;
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        poll_answer    = 1'b0;

        if (cmd.tick)
        begin
            flags_next.check_pending   = cp1;
            flags_next.check_late      = late1 | ((sw1 > LATE_LIMIT) && cp1);
            flags_next.clients_pending = flags_reg.clients_pending
                                         | ((ph1 < CLIENT_WINDOW) && !cp1);
            stopwatch_next = (sw1 != STOPWATCH_MAX) ? sw1 + 16'd1 : sw1;
            phase_next     = (ph_inc >= {1'b0, client_period}) ? 8'd0 : ph_inc[7:0];
        end
        else if (cmd.take_check)
        begin
            poll_answer = flags_reg.check_pending;
            flags_next.check_pending = 1'b0;
        end
        else if (cmd.take_late)
        begin
            poll_answer = flags_reg.check_late;
            flags_next.check_late = 1'b0;
        end
        else if (cmd.take_clients)
        begin
            poll_answer = flags_reg.clients_pending;
            flags_next.clients_pending = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopwatch_reg <= '0;
            phase_reg     <= '0;
            flags_reg     <= '0;
        end
        else if (fire)
        begin
            stopwatch_reg <= stopwatch_next;
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/time_of_day_clock_with_check_flags_core.sv @@
// Time-of-day clock core with check/late/clients flags: top level.
// An accepted beat is held in the input register and moves into the result
// register once that register is free; out_valid then rises.
// Throughput: one beat per cycle while out_stall does not hold the result
// register; the single-pass update between the two registers sets this figure.
// Reset (rst_n, async low): time, stopwatch, phase and flags clear; the
// periods return to 120 and 30 ticks. Depends on tod_pkg, tod_time, tod_flags.
`default_nettype none
`include "time_of_day_clock_with_check_flags_core_defines.svh"
module time_of_day_clock_with_check_flags_core
    import tod_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    // input beats
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    // result beats
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data
);

    // configuration registers
    logic [15:0] check_period_reg;
    logic [7:0]  client_period_reg;

    // input register stage
    logic     pipe_valid_reg;
    in_item_t pipe_item_reg;

    // result register stage
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic             out_free;
    logic             fire;
    logic             in_take;
    tod_cmd_t         cmd;
    tod_time_t        time_next;
    logic             set_ok;
    logic             poll_answer;
    tod_flag_status_t status;
    out_item_t        result;
    logic             flags_clash;
    logic             out_time_legal;

    // The result register is free when empty or being drained this cycle;
    // the held beat then moves through and a new one may enter.
    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = pipe_valid_reg && out_free;
    assign in_stall  = pipe_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes must land only while idle; the block does not enforce it and has no interlock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_period_reg  <= CHECK_PERIOD_RESET;
            client_period_reg <= CLIENT_PERIOD_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_CHECK_PERIOD:  check_period_reg  <= cfg_data;
                CFG_CLIENT_PERIOD: client_period_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Decode the held beat; unused codes decode to no action at all.
    always_comb
    begin
        cmd = '0;
        case (pipe_item_reg.func)
            FUNC_TICK:         cmd.tick         = 1'b1;
            FUNC_SET_TIME:     cmd.set_time     = 1'b1;
            FUNC_TAKE_CHECK:   cmd.take_check   = 1'b1;
            FUNC_TAKE_LATE:    cmd.take_late    = 1'b1;
            FUNC_TAKE_CLIENTS: cmd.take_clients = 1'b1;
            default:           cmd = '0;
        endcase
    end

    tod_time u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .cmd       (cmd),
        .item      (pipe_item_reg),
        .time_next (time_next),
        .set_ok    (set_ok)
    );

    tod_flags u_flags (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .cmd           (cmd),
        .check_period  (check_period_reg),
        .client_period (client_period_reg),
        .poll_answer   (poll_answer),
        .status        (status)
    );

    // The result carries the time after the step; answer is the set verdict
    // or the polled flag (poll_answer is zero for anything but a poll).
    always_comb
    begin
        result.hour_now   = time_next.hour;
        result.minute_now = time_next.minute;
        result.second_now = time_next.second;
        result.answer     = set_ok | poll_answer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                pipe_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                pipe_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pipe_item_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    // Helper terms for the checks below
    assign flags_clash    = status.check_pending && status.clients_pending;
    assign out_time_legal = (out_data_reg.hour_now <= MAX_HOUR)
                            && (out_data_reg.minute_now < UNITS_PER_MINUTE)
                            && (out_data_reg.second_now < UNITS_PER_MINUTE);

    // Input only backs up when a beat is held and the result side is blocked.
    `TOD_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, pipe_valid_reg && !out_free)
    // A beat that moves out of the input register always appears as a result.
    `TOD_ASSERT_NEXT(a_fire_delivers, clk, rst_n, fire, out_valid_reg)
    // A check request blocks the clients window and the reverse.
    `TOD_ASSERT_NOW(a_flags_exclusive, clk, rst_n, 1'b1, !flags_clash)
    // Reported time is always a legal time of day.
    `TOD_ASSERT_NOW(a_time_range, clk, rst_n, out_valid_reg, out_time_legal)

endmodule
`default_nettype wire
